### rtl/pack_object_header_decoder_top_defines.svh
// Assertion macros for the packed-object header decoder.
`ifndef PACK_OBJECT_HEADER_DECODER_TOP_DEFINES_SVH
`define PACK_OBJECT_HEADER_DECODER_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define POHD_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("pohd assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define POHD_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("pohd assertion failed");

`endif

### rtl/pohd_pkg.sv
// Package: types and constants of the packed-object header decoder.
package pohd_pkg;

   localparam int HASH_BYTES         = 32;
   localparam int HASH_COUNT_WIDTH   = $clog2(HASH_BYTES);

   typedef logic [HASH_COUNT_WIDTH-1:0] hash_count_type;

   localparam hash_count_type HASH_LAST = hash_count_type'(HASH_BYTES - 1);

   localparam logic [63:0] DIST_LIMIT  = (64'hFFFF_FFFF_FFFF_FFFF >> 7) - 64'd1;
   localparam logic [6:0]  SIZE_SHIFT_INIT = 7'd4;
   localparam logic [6:0]  SIZE_SHIFT_STEP = 7'd7;
   localparam logic [6:0]  SIZE_SHIFT_STOP = 7'd64;

   localparam logic [2:0] TYPE_OFS_DELTA = 3'd6;
   localparam logic [2:0] TYPE_REF_DELTA = 3'd7;

   localparam logic KIND_HEADER = 1'b0;
   localparam logic KIND_HASH   = 1'b1;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [1:0] ERR_DISTANCE = 2'd2;

   typedef enum logic [1:0] {
      PHASE_IDLE,
      PHASE_SIZE,
      PHASE_DIST,
      PHASE_HASH
   } phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_req;
      logic [63:0] object_offset;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  object_type;
      logic [63:0] object_size;
      logic        delta_flag;
      logic [63:0] delta_base;
      logic [1:0]  error;
      logic [7:0]  hash_byte;
      logic        last;
   } result_type;

endpackage

### rtl/pohd_req_if.sv
// Interface: input byte channel of the packed-object header decoder.
interface pohd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        start_req;
   logic [63:0] object_offset;

   modport source (output valid, output data_byte, output start_req, output object_offset,
                   input ready);
   modport sink   (input valid, input data_byte, input start_req, input object_offset,
                   output ready);
endinterface

### rtl/pohd_rsp_if.sv
// Interface: result channel of the packed-object header decoder.
interface pohd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [2:0]  object_type;
   logic [63:0] object_size;
   logic        delta_flag;
   logic [63:0] delta_base;
   logic [1:0]  error;
   logic [7:0]  hash_byte;
   logic        last;

   modport source (output valid, output kind, output object_type, output object_size,
                   output delta_flag, output delta_base, output error, output hash_byte,
                   output last, input ready);
   modport sink   (input valid, input kind, input object_type, input object_size,
                   input delta_flag, input delta_base, input error, input hash_byte,
                   input last, output ready);
endinterface

### rtl/pohd_in_stage.sv
// Input register stage: capture one byte item from the request channel.
module pohd_in_stage (
   input  logic               clock,
   input  logic               reset,
   pohd_req_if.sink           req_chan,
   input  logic               advance,
   output logic               in_valid,
   output pohd_pkg::item_type in_item
);

   logic               valid_ff;
   logic               valid_in;
   pohd_pkg::item_type item_ff;
   logic               accept;

   assign req_chan.ready = !valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte     <= req_chan.data_byte;
         item_ff.start_req     <= req_chan.start_req;
         item_ff.object_offset <= req_chan.object_offset;
      end
   end

   assign in_valid = valid_ff;
   assign in_item  = item_ff;

endmodule

### rtl/pohd_core.sv
// Decode core: header state, size and distance varints, hash pass-through.
module pohd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  pohd_pkg::item_type   in_item,
   input  logic                 advance,
   output logic                 res_valid,
   output pohd_pkg::result_type res
);

   pohd_pkg::phase_type      phase_ff, phase_in;
   logic [2:0]               type_ff, type_in;
   logic [63:0]              size_ff, size_in;
   logic [6:0]               shift_ff, shift_in;
   logic [63:0]              dist_ff, dist_in;
   logic [63:0]              dist_p1_ff, dist_p1_in;
   logic                     dist_started_ff, dist_started_in;
   logic [63:0]              offset_ff, offset_in;
   pohd_pkg::hash_count_type hash_count_ff, hash_count_in;

   logic        fire;
   logic [6:0]  b7;
   logic        cont;
   logic        hdr_end;
   logic        dist_end;
   logic        dist_ovf;
   logic        hash_end;
   logic [63:0] dist_next;
   logic [64:0] diff;

   assign fire = in_valid && advance;
   assign b7   = in_item.data_byte[6:0];
   assign cont = in_item.data_byte[7];
   assign dist_next = {dist_p1_ff[56:0], b7};
   assign diff = {1'b0, offset_ff} - {1'b0, dist_in};
   assign hash_end = hash_count_ff >= pohd_pkg::HASH_LAST;

   // datapath update and events
   always_comb begin
      type_in         = type_ff;
      size_in         = size_ff;
      shift_in        = shift_ff;
      dist_in         = dist_ff;
      dist_p1_in      = dist_p1_ff;
      dist_started_in = dist_started_ff;
      offset_in       = offset_ff;
      hash_count_in   = hash_count_ff;
      hdr_end         = 1'b0;
      dist_end        = 1'b0;
      dist_ovf        = 1'b0;
      if (fire) begin
         if (in_item.start_req) begin
            offset_in       = in_item.object_offset;
            type_in         = in_item.data_byte[6:4];
            size_in         = {60'd0, in_item.data_byte[3:0]};
            shift_in        = pohd_pkg::SIZE_SHIFT_INIT;
            dist_in         = 64'd0;
            dist_p1_in      = 64'd1;
            dist_started_in = 1'b0;
            hash_count_in   = '0;
            hdr_end         = !cont;
         end else begin
            case (phase_ff)
               pohd_pkg::PHASE_SIZE: begin
                  if (shift_ff < pohd_pkg::SIZE_SHIFT_STOP) begin
                     size_in  = size_ff | ({57'd0, b7} << shift_ff[5:0]);
                     shift_in = shift_ff + pohd_pkg::SIZE_SHIFT_STEP;
                  end
                  hdr_end = !cont;
               end
               pohd_pkg::PHASE_DIST: begin
                  if (!dist_started_ff) begin
                     dist_in         = {57'd0, b7};
                     dist_p1_in      = {57'd0, b7} + 64'd1;
                     dist_started_in = 1'b1;
                     dist_end        = !cont;
                  end else if (dist_ff > pohd_pkg::DIST_LIMIT) begin
                     dist_ovf = 1'b1;
                  end else begin
                     dist_in    = dist_next;
                     dist_p1_in = dist_next + 64'd1;
                     dist_end   = !cont;
                  end
               end
               pohd_pkg::PHASE_HASH: begin
                  if (!hash_end) begin
                     hash_count_in = pohd_pkg::hash_count_type'(hash_count_ff + 1'b1);
                  end
               end
               default: begin
               end
            endcase
         end
         if (hdr_end && type_in == pohd_pkg::TYPE_OFS_DELTA) begin
            dist_in         = 64'd0;
            dist_p1_in      = 64'd1;
            dist_started_in = 1'b0;
         end
         if (hdr_end && type_in == pohd_pkg::TYPE_REF_DELTA) begin
            hash_count_in = '0;
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (in_item.start_req) begin
            phase_in = cont ? pohd_pkg::PHASE_SIZE : pohd_pkg::PHASE_IDLE;
         end else if (phase_ff == pohd_pkg::PHASE_HASH && hash_end) begin
            phase_in = pohd_pkg::PHASE_IDLE;
         end
         if (dist_end || dist_ovf) begin
            phase_in = pohd_pkg::PHASE_IDLE;
         end
         if (hdr_end) begin
            case (type_in)
               pohd_pkg::TYPE_OFS_DELTA: phase_in = pohd_pkg::PHASE_DIST;
               pohd_pkg::TYPE_REF_DELTA: phase_in = pohd_pkg::PHASE_HASH;
               default:                  phase_in = pohd_pkg::PHASE_IDLE;
            endcase
         end
      end
   end

   // result
   always_comb begin
      res_valid       = 1'b0;
      res.kind        = pohd_pkg::KIND_HEADER;
      res.object_type = type_in;
      res.object_size = size_in;
      res.delta_flag  = type_in == pohd_pkg::TYPE_OFS_DELTA ||
                        type_in == pohd_pkg::TYPE_REF_DELTA;
      res.delta_base  = 64'd0;
      res.error       = pohd_pkg::ERR_NONE;
      res.hash_byte   = 8'd0;
      res.last        = 1'b1;
      if (hdr_end) begin
         res_valid = type_in != pohd_pkg::TYPE_OFS_DELTA;
         res.last  = type_in != pohd_pkg::TYPE_REF_DELTA;
      end
      if (dist_ovf) begin
         res_valid = 1'b1;
         res.error = pohd_pkg::ERR_OVERFLOW;
      end
      if (dist_end) begin
         res_valid = 1'b1;
         if (diff[64]) begin
            res.error = pohd_pkg::ERR_DISTANCE;
         end else begin
            res.delta_base = diff[63:0];
         end
      end
      if (fire && !in_item.start_req && phase_ff == pohd_pkg::PHASE_HASH) begin
         res_valid     = 1'b1;
         res.kind      = pohd_pkg::KIND_HASH;
         res.hash_byte = in_item.data_byte;
         res.last      = hash_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= pohd_pkg::PHASE_IDLE;
         type_ff         <= 3'd0;
         size_ff         <= 64'd0;
         shift_ff        <= pohd_pkg::SIZE_SHIFT_INIT;
         dist_ff         <= 64'd0;
         dist_p1_ff      <= 64'd1;
         dist_started_ff <= 1'b0;
         offset_ff       <= 64'd0;
         hash_count_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         type_ff         <= type_in;
         size_ff         <= size_in;
         shift_ff        <= shift_in;
         dist_ff         <= dist_in;
         dist_p1_ff      <= dist_p1_in;
         dist_started_ff <= dist_started_in;
         offset_ff       <= offset_in;
         hash_count_ff   <= hash_count_in;
      end
   end

endmodule

### rtl/pohd_out_stage.sv
// Result register stage: hold one result item until the receiver takes it.
module pohd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  pohd_pkg::result_type res,
   output logic                 advance,
   pohd_rsp_if.source           rsp_chan
);

   logic                 valid_ff;
   logic                 valid_in;
   pohd_pkg::result_type res_ff;

   assign advance = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (advance) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.kind        = res_ff.kind;
   assign rsp_chan.object_type = res_ff.object_type;
   assign rsp_chan.object_size = res_ff.object_size;
   assign rsp_chan.delta_flag  = res_ff.delta_flag;
   assign rsp_chan.delta_base  = res_ff.delta_base;
   assign rsp_chan.error       = res_ff.error;
   assign rsp_chan.hash_byte   = res_ff.hash_byte;
   assign rsp_chan.last        = res_ff.last;

endmodule

### rtl/pack_object_header_decoder_top.sv
// Top level of the packed-object header decoder.
//
// req_chan takes one header byte per item. start_req marks the first byte of
// an object header and carries the object's pack offset in object_offset.
// rsp_chan gives at most one result item per byte: the decoded header (type,
// size, delta flag, base offset and error for offset deltas), then for a
// reference delta one item per base-hash byte, with last on the final one.
// A byte is taken into the input register, then decoded into the result
// register, from which its result leaves.
// Throughput: one byte per cycle unless stalled; the size and distance varints
// each update a running register per byte, so no byte waits on another.
// A start byte always begins a new header; an unfinished one yields nothing.
// Bytes without start_req while idle are dropped.
// Reset (synchronous, active high) empties both stages and returns to idle.
// When the receiver stalls, the result register holds its item; the input
// register still takes one byte, then ready drops until the result drains.
`include "pack_object_header_decoder_top_defines.svh"

module pack_object_header_decoder_top (
   input  logic       clock,
   input  logic       reset,
   pohd_req_if.sink   req_chan,
   pohd_rsp_if.source rsp_chan
);

   logic                 advance;
   logic                 in_valid;
   pohd_pkg::item_type   in_item;
   logic                 res_valid;
   pohd_pkg::result_type res;

   pohd_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .in_valid (in_valid),
      .in_item  (in_item)
   );

   pohd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res)
   );

   pohd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .advance   (advance),
      .rsp_chan  (rsp_chan)
   );

   `POHD_ASSERT_NOW(a_hash_is_ref_delta, clock, reset,
      rsp_chan.valid && rsp_chan.kind == pohd_pkg::KIND_HASH,
      rsp_chan.object_type == pohd_pkg::TYPE_REF_DELTA && rsp_chan.delta_flag &&
      rsp_chan.error == pohd_pkg::ERR_NONE && rsp_chan.delta_base == 64'd0)

   `POHD_ASSERT_NOW(a_error_ends_header, clock, reset,
      rsp_chan.valid && rsp_chan.error != pohd_pkg::ERR_NONE,
      rsp_chan.last && rsp_chan.delta_base == 64'd0 &&
      rsp_chan.object_type == pohd_pkg::TYPE_OFS_DELTA)

   `POHD_ASSERT_NOW(a_open_header_is_ref, clock, reset,
      rsp_chan.valid && rsp_chan.kind == pohd_pkg::KIND_HEADER && !rsp_chan.last,
      rsp_chan.object_type == pohd_pkg::TYPE_REF_DELTA)

   `POHD_ASSERT_NEXT(a_stall_holds_byte, clock, reset,
      in_valid && !advance,
      in_valid && $stable(in_item))

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the packed-object header decoder: random byte streams, scoreboard.
module tb_top;

   localparam int ITEM_TARGET   = 1750;
   localparam int MODE_LEN      = 150;
   localparam int WATCHDOG_MAX  = 5000;
   localparam int SETTLE_CYCLES = 10;
   localparam int PRINT_MAX     = 40;
   localparam int IDLE_HEAVY    = 88;
   localparam int IDLE_MIXED    = 26;

   typedef struct {
      pohd_pkg::item_type it;
      int                 idle_pct;
      int                 stall_pct;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pohd_req_if req_if();
   pohd_rsp_if rsp_if();

   pack_object_header_decoder_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #5 clock = ~clock;

   pohd_pkg::phase_type      hdr_phase;
   logic [2:0]               hdr_type;
   logic [63:0]              hdr_size;
   logic [6:0]               hdr_shift;
   logic [63:0]              hdr_dist;
   logic [63:0]              hdr_offset;
   pohd_pkg::hash_count_type hdr_count;
   logic                     hdr_dist_seen;

   pohd_pkg::result_type decoded_q[$];
   stim_type             byte_q[$];
   stim_type             head;
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;
   int                   stall_pct = 0;
   int                   cur_idle = 0;
   int                   cur_stall = 0;
   int                   stim_total = 0;
   logic                 req_fired = 1'b0;
   bit                   draining = 1'b0;

   function automatic pohd_pkg::result_type form_result(logic kind, logic [63:0] base,
                                                        logic [1:0] err, logic [7:0] hb,
                                                        logic fin);
      pohd_pkg::result_type r;
      r.kind        = kind;
      r.object_type = hdr_type;
      r.object_size = hdr_size;
      r.delta_flag  = (hdr_type == pohd_pkg::TYPE_OFS_DELTA) ||
                      (hdr_type == pohd_pkg::TYPE_REF_DELTA);
      r.delta_base  = base;
      r.error       = err;
      r.hash_byte   = hb;
      r.last        = fin;
      return r;
   endfunction

   function automatic bit end_of_size(output pohd_pkg::result_type r);
      r = '0;
      if (hdr_type == pohd_pkg::TYPE_OFS_DELTA) begin
         hdr_phase     = pohd_pkg::PHASE_DIST;
         hdr_dist      = '0;
         hdr_dist_seen = 1'b0;
         return 1'b0;
      end
      if (hdr_type == pohd_pkg::TYPE_REF_DELTA) begin
         hdr_phase = pohd_pkg::PHASE_HASH;
         hdr_count = '0;
         r = form_result(pohd_pkg::KIND_HEADER, '0, pohd_pkg::ERR_NONE, 8'h00, 1'b0);
         return 1'b1;
      end
      hdr_phase = pohd_pkg::PHASE_IDLE;
      r = form_result(pohd_pkg::KIND_HEADER, '0, pohd_pkg::ERR_NONE, 8'h00, 1'b1);
      return 1'b1;
   endfunction

   function automatic pohd_pkg::result_type end_of_distance(bit overflow);
      hdr_phase = pohd_pkg::PHASE_IDLE;
      if (overflow)
         return form_result(pohd_pkg::KIND_HEADER, '0, pohd_pkg::ERR_OVERFLOW, 8'h00, 1'b1);
      if (hdr_dist > hdr_offset)
         return form_result(pohd_pkg::KIND_HEADER, '0, pohd_pkg::ERR_DISTANCE, 8'h00, 1'b1);
      return form_result(pohd_pkg::KIND_HEADER, hdr_offset - hdr_dist, pohd_pkg::ERR_NONE,
                         8'h00, 1'b1);
   endfunction

   function automatic bit decode_byte(pohd_pkg::item_type it,
                                      output pohd_pkg::result_type r);
      logic [7:0] b;
      b = it.data_byte;
      r = '0;
      if (it.start_req) begin
         hdr_offset    = it.object_offset;
         hdr_type      = b[6:4];
         hdr_size      = 64'(b[3:0]);
         hdr_shift     = pohd_pkg::SIZE_SHIFT_INIT;
         hdr_dist      = '0;
         hdr_count     = '0;
         hdr_dist_seen = 1'b0;
         if (b[7]) begin
            hdr_phase = pohd_pkg::PHASE_SIZE;
            return 1'b0;
         end
         return end_of_size(r);
      end
      case (hdr_phase)
         pohd_pkg::PHASE_SIZE: begin
            if (hdr_shift < pohd_pkg::SIZE_SHIFT_STOP) begin
               hdr_size  = hdr_size | (64'(b[6:0]) << hdr_shift);
               hdr_shift = hdr_shift + pohd_pkg::SIZE_SHIFT_STEP;
            end
            if (b[7])
               return 1'b0;
            return end_of_size(r);
         end
         pohd_pkg::PHASE_DIST: begin
            if (!hdr_dist_seen) begin
               hdr_dist      = 64'(b[6:0]);
               hdr_dist_seen = 1'b1;
            end else if (hdr_dist > pohd_pkg::DIST_LIMIT) begin
               r = end_of_distance(1'b1);
               return 1'b1;
            end else begin
               hdr_dist = ((hdr_dist + 64'd1) << 7) | 64'(b[6:0]);
            end
            if (b[7])
               return 1'b0;
            r = end_of_distance(1'b0);
            return 1'b1;
         end
         pohd_pkg::PHASE_HASH: begin
            r = form_result(pohd_pkg::KIND_HASH, '0, pohd_pkg::ERR_NONE, b,
                            hdr_count == pohd_pkg::HASH_LAST);
            if (hdr_count == pohd_pkg::HASH_LAST)
               hdr_phase = pohd_pkg::PHASE_IDLE;
            else
               hdr_count = hdr_count + 1'b1;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_MAX)
         $display("tb_top: mismatch %s got %0h want %0h at %0t", what, got, want, $time);
   endtask

   task automatic check_result();
      pohd_pkg::result_type want;
      if (decoded_q.size() == 0) begin
         report_mismatch("result with none pending, size", rsp_if.object_size, '0);
         return;
      end
      want = decoded_q.pop_front();
      if (rsp_if.kind !== want.kind)
         report_mismatch("kind", rsp_if.kind, want.kind);
      if (rsp_if.object_type !== want.object_type)
         report_mismatch("object_type", rsp_if.object_type, want.object_type);
      if (rsp_if.object_size !== want.object_size)
         report_mismatch("object_size", rsp_if.object_size, want.object_size);
      if (rsp_if.delta_flag !== want.delta_flag)
         report_mismatch("delta_flag", rsp_if.delta_flag, want.delta_flag);
      if (rsp_if.delta_base !== want.delta_base)
         report_mismatch("delta_base", rsp_if.delta_base, want.delta_base);
      if (rsp_if.error !== want.error)
         report_mismatch("error", rsp_if.error, want.error);
      if (rsp_if.hash_byte !== want.hash_byte)
         report_mismatch("hash_byte", rsp_if.hash_byte, want.hash_byte);
      if (rsp_if.last !== want.last)
         report_mismatch("last", rsp_if.last, want.last);
   endtask

   task automatic note_item();
      pohd_pkg::item_type   it;
      pohd_pkg::result_type r;
      it.data_byte     = req_if.data_byte;
      it.start_req     = req_if.start_req;
      it.object_offset = req_if.object_offset;
      if (decode_byte(it, r))
         decoded_q.insert(decoded_q.size(), r);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_fired    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_result();
         if (req_if.valid && req_if.ready)
            note_item();
         req_fired <= req_if.valid && req_if.ready;
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb_top: done, errors");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         rsp_if.ready <= draining || ($urandom_range(99) >= stall_pct);
         if (!req_if.valid || req_fired) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= byte_q[0].idle_pct) begin
               head = byte_q.pop_front();
               req_if.valid         <= 1'b1;
               req_if.data_byte     <= head.it.data_byte;
               req_if.start_req     <= head.it.start_req;
               req_if.object_offset <= head.it.object_offset;
               stall_pct            <= head.stall_pct;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] pick_offset();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'($urandom_range(4095));
         3: return rand64() >> $urandom_range(63);
         default: return rand64();
      endcase
   endfunction

   function automatic int pick_len();
      return ($urandom_range(9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 3);
   endfunction

   task automatic put_byte(logic [7:0] b, logic s, logic [63:0] ofs);
      stim_type e;
      e.it.data_byte     = b;
      e.it.start_req     = s;
      e.it.object_offset = ofs;
      e.idle_pct         = cur_idle;
      e.stall_pct        = cur_stall;
      byte_q.insert(byte_q.size(), e);
      stim_total++;
   endtask

   task automatic send_header(logic [2:0] t, int nbytes, logic [63:0] ofs);
      put_byte({nbytes > 1, t, 4'($urandom)}, 1'b1, ofs);
      for (int i = 1; i < nbytes; i++)
         put_byte({i < nbytes - 1, 7'($urandom)}, 1'b0, rand64());
   endtask

   task automatic send_distance(int nbytes, bit wide);
      for (int i = 0; i < nbytes; i++)
         put_byte({i < nbytes - 1, wide ? 7'h7F : 7'($urandom)}, 1'b0, rand64());
   endtask

   task automatic set_mode(int m);
      case (m)
         0: begin
            cur_idle  = 0;
            cur_stall = 0;
         end
         1: begin
            cur_idle  = IDLE_HEAVY;
            cur_stall = 0;
         end
         2: begin
            cur_idle  = 0;
            cur_stall = IDLE_HEAVY;
         end
         default: begin
            cur_idle  = IDLE_MIXED;
            cur_stall = IDLE_MIXED;
         end
      endcase
   endtask

   task automatic send_object();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 30) begin
         send_header(3'($urandom_range(5)), pick_len(), pick_offset());
      end else if (pick < 60) begin
         send_header(pohd_pkg::TYPE_OFS_DELTA, pick_len(), pick_offset());
         n = $urandom_range(9);
         if (n == 0)
            send_distance($urandom_range(10, 12), 1'b1);
         else if (n == 1)
            send_distance($urandom_range(5, 10), 1'b0);
         else
            send_distance($urandom_range(1, 4), 1'b0);
      end else if (pick < 85) begin
         send_header(pohd_pkg::TYPE_REF_DELTA, pick_len(), pick_offset());
         n = ($urandom_range(19) == 0) ? $urandom_range(pohd_pkg::HASH_BYTES - 1)
                                       : pohd_pkg::HASH_BYTES;
         for (int i = 0; i < n; i++)
            put_byte(8'($urandom), 1'b0, rand64());
      end else if (pick < 93) begin
         n = $urandom_range(1, 3);
         for (int i = 0; i < n; i++)
            put_byte(8'($urandom), 1'b0, rand64());
      end else begin
         put_byte({1'b1, 7'($urandom)}, 1'b1, pick_offset());
         if ($urandom_range(1))
            put_byte({1'b1, 7'($urandom)}, 1'b0, rand64());
      end
   endtask

   initial begin
      req_if.valid         = 1'b0;
      req_if.data_byte     = '0;
      req_if.start_req     = 1'b0;
      req_if.object_offset = '0;
      rsp_if.ready         = 1'b0;
      hdr_phase            = pohd_pkg::PHASE_IDLE;
      hdr_type             = '0;
      hdr_size             = '0;
      hdr_shift            = pohd_pkg::SIZE_SHIFT_INIT;
      hdr_dist             = '0;
      hdr_offset           = '0;
      hdr_count            = '0;
      hdr_dist_seen        = 1'b0;

      set_mode(0);
      put_byte(8'hFF, 1'b0, '1);
      put_byte(8'h10, 1'b1, '0);
      // size varint running past 64 bits
      put_byte(8'hBF, 1'b1, '1);
      for (int i = 0; i < 9; i++)
         put_byte(8'hFF, 1'b0, rand64());
      put_byte(8'h7F, 1'b0, rand64());
      put_byte(8'h65, 1'b1, '0);
      put_byte(8'h00, 1'b0, '1);
      // distance above the object offset
      put_byte(8'h60, 1'b1, '0);
      put_byte(8'h01, 1'b0, '0);
      // cut a hash pass-through short, then restart mid-header
      put_byte(8'h70, 1'b1, '1);
      put_byte(8'hAA, 1'b0, '0);
      put_byte(8'hC0, 1'b1, rand64());
      put_byte(8'h4F, 1'b1, '1);
      put_byte(8'h00, 1'b1, rand64());
      put_byte(8'h5F, 1'b1, rand64());

      while (stim_total < ITEM_TARGET) begin
         set_mode((stim_total / MODE_LEN) % 4);
         send_object();
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_if.valid)
         @(posedge clock);
      draining = 1'b1;
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/pohd_pkg.sv
rtl/pohd_req_if.sv
rtl/pohd_rsp_if.sv
rtl/pohd_in_stage.sv
rtl/pohd_core.sv
rtl/pohd_out_stage.sv
rtl/pack_object_header_decoder_top.sv
tb/tb_top.sv
